/* rtl/slpg_pkg.sv */
package slpg_pkg;

  localparam int LEVEL_BITS_DEF = 8;
  localparam int OUT_W          = 8;
  localparam int STATUS_W       = 3;
  localparam int MODE_W         = 3;

  // half periods in ms of the 200, 400 and 2000 ms patterns
  localparam int HALF_SHORT = 100;
  localparam int HALF_MID   = 200;
  localparam int HALF_LONG  = 1000;

  typedef enum logic [1:0] {
    PER_SHORT = 2'd0,
    PER_MID   = 2'd1,
    PER_LONG  = 2'd2
  } period_code_t;

  // bit 2 red, bit 1 green, bit 0 blue
  typedef struct packed {
    logic [2:0] start_color;
    logic [2:0] end_color;
  } color_pair_t;

  typedef struct packed {
    color_pair_t  colors;
    logic         square_wave_select;
    period_code_t period_code;
  } pattern_t;

endpackage

/* rtl/slpg_ratio_track.sv */
// keeps phase, quotient and remainder of LEVEL_MAX*|p-HALF|/HALF for one period,
// stepped by one ms per tick
module slpg_ratio_track #(
  parameter int HALF       = slpg_pkg::HALF_SHORT,
  parameter int LEVEL_BITS = slpg_pkg::LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  output logic [LEVEL_BITS-1:0] quot,
  output logic                  first_half,
  output logic                  at_half
);

  localparam int PW     = $clog2(2 * HALF);
  localparam int RW     = $clog2(HALF);
  localparam int LMAX   = (1 << LEVEL_BITS) - 1;
  localparam int Q_STEP = LMAX / HALF;
  localparam int R_STEP = LMAX % HALF;

  localparam logic [PW-1:0]         PH_HALF = PW'(HALF);
  localparam logic [PW-1:0]         PH_LAST = PW'(2 * HALF - 1);
  localparam logic [RW:0]           R_STEPW = (RW + 1)'(R_STEP);
  localparam logic [RW:0]           R_DIV   = (RW + 1)'(HALF);
  localparam logic [LEVEL_BITS-1:0] Q_STEPW = LEVEL_BITS'(Q_STEP);
  localparam logic [LEVEL_BITS-1:0] Q_MAX   = '1;

  logic [PW-1:0]         phase;
  logic [PW-1:0]         phase_next;
  logic [RW-1:0]         rem;
  logic [RW-1:0]         rem_next;
  logic [LEVEL_BITS-1:0] quot_next;
  logic [RW:0]           rem_wide;
  logic [RW:0]           rem_sum;

  assign first_half = phase < PH_HALF;
  assign at_half    = phase == PH_HALF;
  assign rem_wide   = {1'b0, rem};
  assign rem_sum    = rem_wide + R_STEPW;

  always_comb begin
    phase_next = (phase == PH_LAST) ? '0 : phase + 1'b1;
    if (first_half) begin
      // distance to mid period shrinks by one
      if (rem_wide >= R_STEPW) begin
        rem_next  = RW'(rem_wide - R_STEPW);
        quot_next = quot - Q_STEPW;
      end else begin
        rem_next  = RW'(rem_wide + R_DIV - R_STEPW);
        quot_next = quot - Q_STEPW - 1'b1;
      end
    end else begin
      // distance grows by one, also across the wrap to phase zero
      if (rem_sum >= R_DIV) begin
        rem_next  = RW'(rem_sum - R_DIV);
        quot_next = quot + Q_STEPW + 1'b1;
      end else begin
        rem_next  = RW'(rem_sum);
        quot_next = quot + Q_STEPW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      rem   <= '0;
      quot  <= Q_MAX;
    end else if (step) begin
      phase <= phase_next;
      rem   <= rem_next;
      quot  <= quot_next;
    end
  end

  a_full_at_start: assert property (@(posedge clk) disable iff (rst)
    phase == '0 |-> quot == Q_MAX && rem == '0)
    else $error("ratio not full at period start");

  a_zero_at_half: assert property (@(posedge clk) disable iff (rst)
    at_half |-> quot == '0 && rem == '0)
    else $error("ratio not zero at mid period");

endmodule

/* rtl/slpg_pattern_sel.sv */
module slpg_pattern_sel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [slpg_pkg::STATUS_W-1:0] run_state,
  input  logic [slpg_pkg::MODE_W-1:0]   control_mode,
  output slpg_pkg::pattern_t            pattern_cur
);

  typedef enum logic [2:0] {
    RS_ACTIVE    = 3'd0,
    RS_INACTIVE  = 3'd1,
    RS_CALIBRATE = 3'd2,
    RS_BEEP      = 3'd3,
    RS_ERROR     = 3'd4,
    RS_WARN      = 3'd5
  } run_state_t;

  typedef enum logic [2:0] {
    CM_CURRENT  = 3'd0,
    CM_POSITION = 3'd1,
    CM_SPEED    = 3'd2,
    CM_TEACH    = 3'd3
  } control_mode_t;

  localparam logic [2:0] COL_OFF   = 3'b000;
  localparam logic [2:0] COL_BLUE  = 3'b001;
  localparam logic [2:0] COL_GREEN = 3'b010;
  localparam logic [2:0] COL_RED   = 3'b100;
  localparam logic [2:0] COL_WHITE = 3'b111;

  slpg_pkg::pattern_t pattern;

  function automatic slpg_pkg::pattern_t pat(
    input logic [2:0]             a,
    input logic [2:0]             b,
    input logic                   square,
    input slpg_pkg::period_code_t pc
  );
    slpg_pkg::pattern_t p;
    p.colors.start_color = a;
    p.colors.end_color   = b;
    p.square_wave_select = square;
    p.period_code        = pc;
    return p;
  endfunction

  // unknown codes keep the previous pattern
  always_comb begin
    pattern_cur = pattern;
    unique case (run_state)
      RS_ACTIVE: begin
        unique case (control_mode)
          CM_CURRENT:  pattern_cur = pat(COL_GREEN, COL_OFF, 1'b0, slpg_pkg::PER_MID);
          CM_POSITION: pattern_cur = pat(COL_RED, COL_GREEN, 1'b0, slpg_pkg::PER_MID);
          CM_SPEED:    pattern_cur = pat(COL_BLUE, COL_GREEN, 1'b0, slpg_pkg::PER_MID);
          CM_TEACH:    pattern_cur = pat(COL_WHITE, COL_BLUE, 1'b0, slpg_pkg::PER_MID);
          default:     pattern_cur = pattern;
        endcase
      end
      RS_INACTIVE:  pattern_cur = pat(COL_WHITE, COL_OFF, 1'b0, slpg_pkg::PER_LONG);
      RS_CALIBRATE: pattern_cur = pat(COL_BLUE, COL_OFF, 1'b1, slpg_pkg::PER_SHORT);
      RS_BEEP:      pattern_cur = pat(COL_GREEN, COL_OFF, 1'b1, slpg_pkg::PER_SHORT);
      RS_ERROR, RS_WARN:
                    pattern_cur = pat(COL_RED, COL_OFF, 1'b1, slpg_pkg::PER_SHORT);
      default:      pattern_cur = pattern;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= pat(COL_OFF, COL_OFF, 1'b0, slpg_pkg::PER_SHORT);
    end else if (load) begin
      pattern <= pattern_cur;
    end
  end

endmodule

/* rtl/slpg_level_out.sv */
module slpg_level_out #(
  parameter int LEVEL_BITS = slpg_pkg::LEVEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  logic [LEVEL_BITS-1:0]      s1_ratio,
  input  slpg_pkg::color_pair_t      s1_colors,
  output logic                       ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [slpg_pkg::OUT_W-1:0] red_level,
  output logic [slpg_pkg::OUT_W-1:0] green_level,
  output logic [slpg_pkg::OUT_W-1:0] blue_level
);

  localparam logic [LEVEL_BITS-1:0] LMAX = '1;

  // start*(max-r) + end*r with one-bit start and end
  function automatic logic [slpg_pkg::OUT_W-1:0] mix(
    input logic                  a,
    input logic                  b,
    input logic [LEVEL_BITS-1:0] r
  );
    logic [LEVEL_BITS-1:0] lv;
    case ({a, b})
      2'b11:   lv = LMAX;
      2'b10:   lv = LMAX - r;
      2'b01:   lv = r;
      default: lv = '0;
    endcase
    return slpg_pkg::OUT_W'(lv);
  endfunction

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= s1_valid;
    end
    if (ready && s1_valid) begin
      red_level   <= mix(s1_colors.start_color[2], s1_colors.end_color[2], s1_ratio);
      green_level <= mix(s1_colors.start_color[1], s1_colors.end_color[1], s1_ratio);
      blue_level  <= mix(s1_colors.start_color[0], s1_colors.end_color[0], s1_ratio);
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !s1_valid |=> !out_valid)
    else $error("result shown twice");

endmodule

/* rtl/status_led_pattern_generator_unit.sv */
// Status LED pattern generator: every accepted input transfer is one millisecond tick and
// yields one red/green/blue level triple through the input and then the result register.
// One tick is taken per clock cycle while in_stall is low; the two registers form a
// two-deep pipeline, so input stalls only when both hold an item and the output is stalled.
// The three blink periods each have their own ratio tracker that steps once per tick.
module status_led_pattern_generator_unit #(
  parameter int LEVEL_BITS = slpg_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [slpg_pkg::STATUS_W-1:0] run_state,
  input  logic [slpg_pkg::MODE_W-1:0]   control_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [slpg_pkg::OUT_W-1:0]    red_level,
  output logic [slpg_pkg::OUT_W-1:0]    green_level,
  output logic [slpg_pkg::OUT_W-1:0]    blue_level
);

  localparam logic [LEVEL_BITS-1:0] LMAX  = '1;
  localparam logic [LEVEL_BITS-1:0] LHALF = LMAX >> 1;

  logic                  out_ready;
  logic                  s1_en;
  logic                  accept;
  logic                  s1_valid;
  logic [LEVEL_BITS-1:0] s1_ratio;
  slpg_pkg::color_pair_t s1_colors;
  slpg_pkg::pattern_t    pattern_cur;

  logic [LEVEL_BITS-1:0] q_short, q_mid, q_long;
  logic                  fh_short, fh_mid, fh_long;
  logic                  ah_short, ah_mid, ah_long;
  logic [LEVEL_BITS-1:0] tri_ratio;
  logic                  first_half;
  logic                  at_half;
  logic [LEVEL_BITS-1:0] ratio;

  assign s1_en    = !s1_valid || out_ready;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;

  slpg_pattern_sel u_pattern (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .run_state    (run_state),
    .control_mode (control_mode),
    .pattern_cur  (pattern_cur)
  );

  slpg_ratio_track #(.HALF(slpg_pkg::HALF_SHORT), .LEVEL_BITS(LEVEL_BITS)) u_track_short (
    .clk (clk), .rst (rst), .step (accept),
    .quot (q_short), .first_half (fh_short), .at_half (ah_short)
  );

  slpg_ratio_track #(.HALF(slpg_pkg::HALF_MID), .LEVEL_BITS(LEVEL_BITS)) u_track_mid (
    .clk (clk), .rst (rst), .step (accept),
    .quot (q_mid), .first_half (fh_mid), .at_half (ah_mid)
  );

  slpg_ratio_track #(.HALF(slpg_pkg::HALF_LONG), .LEVEL_BITS(LEVEL_BITS)) u_track_long (
    .clk (clk), .rst (rst), .step (accept),
    .quot (q_long), .first_half (fh_long), .at_half (ah_long)
  );

  always_comb begin
    case (pattern_cur.period_code)
      slpg_pkg::PER_SHORT: begin
        tri_ratio  = q_short;
        first_half = fh_short;
        at_half    = ah_short;
      end
      slpg_pkg::PER_MID: begin
        tri_ratio  = q_mid;
        first_half = fh_mid;
        at_half    = ah_mid;
      end
      default: begin
        tri_ratio  = q_long;
        first_half = fh_long;
        at_half    = ah_long;
      end
    endcase
    if (!pattern_cur.square_wave_select) begin
      ratio = tri_ratio;
    end else if (first_half) begin
      ratio = '0;
    end else if (at_half) begin
      ratio = LHALF;
    end else begin
      ratio = LMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
    if (accept) begin
      s1_ratio  <= ratio;
      s1_colors <= pattern_cur.colors;
    end
  end

  slpg_level_out #(.LEVEL_BITS(LEVEL_BITS)) u_level_out (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_ratio    (s1_ratio),
    .s1_colors   (s1_colors),
    .ready       (out_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
